FILE: src/scc_pkg.sv
// shared types and constants for the system control coprocessor
package scc_pkg;

    localparam logic [63:0] VEC_BASE_BEV  = 64'hFFFF_FFFF_BFC0_0200;
    localparam logic [63:0] VEC_BASE_NORM = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] VEC_GENERAL   = 64'h180;
    localparam logic [31:0] PRID_RESET    = 32'd2850;

    typedef enum logic [2:0] {
        FN_WRITE  = 3'd0,
        FN_READ   = 3'd1,
        FN_RAISE  = 3'd2,
        FN_USABLE = 3'd3,
        FN_TICK   = 3'd4,
        FN_SET    = 3'd5,
        FN_CLEAR  = 3'd6,
        FN_NONE   = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        FLT_NONE   = 2'd0,
        FLT_DOUBLE = 2'd1,
        FLT_REG    = 2'd2,
        FLT_MODE   = 2'd3
    } fault_t;

    localparam logic [4:0] R_INDEX = 5'd0, R_RANDOM = 5'd1, R_ELO0 = 5'd2, R_ELO1 = 5'd3,
        R_CONTEXT = 5'd4, R_PMASK = 5'd5, R_WIRED = 5'd6, R_BADV = 5'd8, R_COUNT = 5'd9,
        R_EHI = 5'd10, R_COMPARE = 5'd11, R_STATUS = 5'd12, R_CAUSE = 5'd13, R_EPC = 5'd14,
        R_PRID = 5'd15, R_CONFIG = 5'd16, R_LLADDR = 5'd17, R_WLO = 5'd18, R_WHI = 5'd19,
        R_XCTX = 5'd20, R_TAGLO = 5'd28, R_ERREPC = 5'd30;

    localparam logic [4:0] EXC_INT = 5'd0, EXC_CPU = 5'd11;
    localparam logic CFG_PRID = 1'b0, CFG_RATIO = 1'b1;

endpackage

FILE: src/system_control_coprocessor_top.sv
// system control coprocessor: register file, exception entry, timer and interrupts
// One request is taken per cycle while the result register can take it. All work for a
// request is done in the cycle it is accepted and its result lands in a single output
// register, valid in the cycle after acceptance; the input is taken while the result
// register is empty or being drained the same cycle.
module system_control_coprocessor_top
    import scc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [4:0]  s_reg_num,
    input  logic [63:0] s_write_data,
    input  logic [4:0]  s_exc_code,
    input  logic [1:0]  s_cop_number,
    input  logic [63:0] s_bad_address,
    input  logic        s_load_bad_address,
    input  logic [63:0] s_pc,
    input  logic        s_in_delay_slot,
    input  logic [2:0]  s_intr_line,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_read_data,
    output logic        m_redirect,
    output logic [63:0] m_redirect_pc,
    output logic        m_usable,
    output logic [1:0]  m_fault
);

    logic [31:0] prid_reg;
    logic [3:0]  ratio_reg;
    logic [31:0] status_reg, status_next, cause_reg, cause_next;
    logic [31:0] count_reg, count_next, compare_reg, compare_next, xctx_reg, xctx_next;
    logic [63:0] epc_reg, epc_next, errepc_reg, errepc_next, badv_reg, badv_next;
    logic [63:0] taglo_reg, taglo_next, lladdr_reg, lladdr_next, wlo_reg, wlo_next;
    logic [36:0] ehi_reg, ehi_next;
    logic [25:0] elo0_reg, elo0_next, elo1_reg, elo1_next;
    logic [11:0] pmask_reg, pmask_next;
    logic [6:0]  index_reg, index_next, cfgf_reg, cfgf_next;
    logic [4:0]  wired_reg, wired_next, random_reg, random_next;
    logic [2:0]  whi_reg, whi_next;

    logic [63:0] rd, tgt;
    logic        took, usable;
    fault_t      flt;
    logic        do_exc, chk;
    logic [4:0]  ecode;
    logic [1:0]  ksu;
    logic [31:0] st_chk;
    logic [63:0] d;
    logic        accept;

    assign s_ready = !m_valid || m_ready;
    assign accept  = s_valid && s_ready;
    assign d = s_write_data;

    always_comb begin
        status_next = status_reg; cause_next = cause_reg; count_next = count_reg;
        compare_next = compare_reg; xctx_next = xctx_reg; epc_next = epc_reg;
        errepc_next = errepc_reg; badv_next = badv_reg; taglo_next = taglo_reg;
        lladdr_next = lladdr_reg; wlo_next = wlo_reg; ehi_next = ehi_reg;
        elo0_next = elo0_reg; elo1_next = elo1_reg; pmask_next = pmask_reg;
        index_next = index_reg; cfgf_next = cfgf_reg; wired_next = wired_reg;
        random_next = random_reg; whi_next = whi_reg;
        rd = '0; usable = 1'b0; flt = FLT_NONE; do_exc = 1'b0; chk = 1'b0;
        ecode = EXC_INT; ksu = status_reg[4:3];
        unique case (func_t'(s_func))
            FN_WRITE: begin
                case (s_reg_num)
                    R_INDEX:   index_next = {d[31], d[5:0]};
                    R_ELO0:    elo0_next = d[25:0];
                    R_ELO1:    elo1_next = d[25:0];
                    R_CONTEXT: flt = FLT_REG;
                    R_PMASK:   pmask_next = d[24:13];
                    R_WIRED: begin
                        wired_next = d[4:0];
                        random_next = 5'd31;
                    end
                    R_BADV:    badv_next = d;
                    R_COUNT:   count_next = d[31:0];
                    R_EHI:     ehi_next = {d[63:62], d[39:13], d[7:0]};
                    R_COMPARE: begin
                        compare_next = d[31:0];
                        cause_next[15] = 1'b0;
                    end
                    R_STATUS: begin
                        status_next = d[31:0];
                        ksu = d[4:3];
                        if (d[27] || d[25] || (d[5] && ksu == 2'd2) ||
                            (d[6] && ksu == 2'd1) || (d[7] && ksu == 2'd0))
                            flt = FLT_MODE;
                        chk = 1'b1;
                    end
                    R_CAUSE: begin
                        cause_next[9:8] = d[9:8];
                        chk = 1'b1;
                    end
                    R_EPC:    epc_next = d;
                    R_CONFIG: cfgf_next = {d[26:24], d[14], d[2], d[1:0]};
                    R_LLADDR: lladdr_next = d;
                    R_WLO:    wlo_next = {d[63:3], 1'b0, d[1:0]};
                    R_WHI:    whi_next = d[2:0];
                    R_XCTX:   xctx_next = d[63:32];
                    R_TAGLO:  taglo_next = d;
                    R_ERREPC: errepc_next = d;
                    default: ;
                endcase
            end
            FN_READ: begin
                case (s_reg_num)
                    R_INDEX:   rd = {32'd0, index_reg[6], 25'd0, index_reg[5:0]};
                    R_RANDOM:  rd = {59'd0, random_reg};
                    R_ELO0:    rd = {38'd0, elo0_reg};
                    R_ELO1:    rd = {38'd0, elo1_reg};
                    R_PMASK:   rd = {39'd0, pmask_reg, 13'd0};
                    R_WIRED:   rd = {59'd0, wired_reg};
                    R_BADV:    rd = badv_reg;
                    R_COUNT:   rd = {32'd0, count_reg};
                    R_EHI:     rd = {ehi_reg[36:35], 22'd0, ehi_reg[34:8], 5'd0, ehi_reg[7:0]};
                    R_COMPARE: rd = {32'd0, compare_reg};
                    R_STATUS:  rd = {32'd0, status_reg};
                    R_CAUSE:   rd = {32'd0, cause_reg};
                    R_EPC:     rd = epc_reg;
                    R_PRID:    rd = {32'd0, prid_reg};
                    // fixed field at 14..4 overlaps the BE bit, whose place reads as one
                    R_CONFIG:  rd = {32'd0, ratio_reg, 1'b0, cfgf_reg[6:4], 5'd0, 4'hD,
                                     (11'h646 | {cfgf_reg[3], 10'd0}), 1'b0,
                                     cfgf_reg[2], cfgf_reg[1:0]};
                    R_LLADDR:  rd = lladdr_reg;
                    R_WLO:     rd = wlo_reg;
                    R_WHI:     rd = {61'd0, whi_reg};
                    R_XCTX:    rd = {xctx_reg[30:0], 33'd0};
                    R_TAGLO:   rd = taglo_reg;
                    R_ERREPC:  rd = errepc_reg;
                    default:   rd = '0;
                endcase
            end
            FN_RAISE: begin
                if (s_load_bad_address) badv_next = s_bad_address;
                if (s_exc_code == EXC_CPU) cause_next[29:28] = s_cop_number;
                do_exc = 1'b1;
                ecode = s_exc_code;
            end
            FN_USABLE: begin
                if (status_reg[28] || status_reg[4:3] == 2'd0) begin
                    usable = 1'b1;
                end else begin
                    cause_next[29:28] = 2'd0;
                    do_exc = 1'b1;
                    ecode = EXC_CPU;
                end
            end
            FN_TICK: begin
                count_next = count_reg + 32'd1;
                random_next = random_reg - 5'd1;
                if (count_next == compare_reg) begin
                    cause_next[15] = 1'b1;
                    chk = 1'b1;
                end
            end
            FN_SET: begin
                cause_next[5'd8 + {2'd0, s_intr_line}] = 1'b1;
                chk = 1'b1;
            end
            FN_CLEAR: cause_next[5'd8 + {2'd0, s_intr_line}] = 1'b0;
            FN_NONE: ;
            default: ;
        endcase

        // interrupt check uses the updated status and cause
        st_chk = status_next;
        if (chk && st_chk[0] && st_chk[2:1] == 2'b00 &&
            (st_chk[15:8] & cause_next[15:8]) != 8'd0) begin
            do_exc = 1'b1;
            ecode = EXC_INT;
        end

        took = 1'b0; tgt = '0;
        if (do_exc) begin
            if (status_next[1]) begin
                flt = FLT_DOUBLE;
            end else begin
                status_next[1] = 1'b1;
                cause_next[6:2] = ecode;
                cause_next[31] = s_in_delay_slot;
                epc_next = s_in_delay_slot ? s_pc - 64'd4 : s_pc;
                took = 1'b1;
                tgt = (status_next[22] ? VEC_BASE_BEV : VEC_BASE_NORM) +
                      ((ecode == 5'd1 || ecode == 5'd2 || ecode == 5'd3) ? 64'd0 : VEC_GENERAL);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prid_reg <= PRID_RESET; ratio_reg <= '0;
            status_reg <= '0; cause_reg <= '0; count_reg <= '0; compare_reg <= '0;
            xctx_reg <= '0; epc_reg <= '0; errepc_reg <= '0; badv_reg <= '0;
            taglo_reg <= '0; lladdr_reg <= '0; wlo_reg <= '0; ehi_reg <= '0;
            elo0_reg <= '0; elo1_reg <= '0; pmask_reg <= '0; index_reg <= '0;
            cfgf_reg <= '0; wired_reg <= '0; random_reg <= 5'd31; whi_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_PRID) prid_reg <= cfg_data;
                else                       ratio_reg <= cfg_data[3:0];
            end
            if (accept) begin
                status_reg <= status_next; cause_reg <= cause_next; count_reg <= count_next;
                compare_reg <= compare_next; xctx_reg <= xctx_next; epc_reg <= epc_next;
                errepc_reg <= errepc_next; badv_reg <= badv_next; taglo_reg <= taglo_next;
                lladdr_reg <= lladdr_next; wlo_reg <= wlo_next; ehi_reg <= ehi_next;
                elo0_reg <= elo0_next; elo1_reg <= elo1_next; pmask_reg <= pmask_next;
                index_reg <= index_next; cfgf_reg <= cfgf_next; wired_reg <= wired_next;
                random_reg <= random_next; whi_reg <= whi_next;
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_read_data   <= rd;
            m_redirect    <= took;
            m_redirect_pc <= tgt;
            m_usable      <= usable;
            m_fault       <= flt;
        end
    end

endmodule

FILE: src/scc_checker.sv
// port-level checks for the system control coprocessor
module scc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_redirect,
    input logic [63:0] m_redirect_pc,
    input logic        m_usable,
    input logic [1:0]  m_fault
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_redirect_pc))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready) else $error("not ready with empty output");

    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid) else $error("request produced no result");

    a_redirect: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_redirect |-> !m_usable && m_fault != 2'd1)
        else $error("redirect with usable or double fault");

    a_nopc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_redirect |-> m_redirect_pc == 64'd0)
        else $error("vector without redirect");

endmodule

bind system_control_coprocessor_top scc_checker u_scc_checker (.*);

FILE: verif/tb_system_control_coprocessor_top.sv
// testbench for the system control coprocessor: self-predicting request driver and result checker
`timescale 1ns / 1ps
module tb_system_control_coprocessor_top;
    import scc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_func;
    logic [4:0]  s_reg_num;
    logic [63:0] s_write_data;
    logic [4:0]  s_exc_code;
    logic [1:0]  s_cop_number;
    logic [63:0] s_bad_address;
    logic        s_load_bad_address;
    logic [63:0] s_pc;
    logic        s_in_delay_slot;
    logic [2:0]  s_intr_line;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_read_data;
    logic        m_redirect;
    logic [63:0] m_redirect_pc;
    logic        m_usable;
    logic [1:0]  m_fault;

    system_control_coprocessor_top dut (.*);

    typedef struct packed {
        logic [63:0] read_data;
        logic        redirect;
        logic [63:0] redirect_pc;
        logic        usable;
        fault_t      fault;
    } cop_result_t;

    cop_result_t result_q[$];
    int          err_count;
    int          cycle_count;
    bit          sender_calm;
    bit          receiver_calm;
    int          hold_off;

    // predicted coprocessor state
    logic [31:0] p_prid;
    logic [3:0]  p_ratio;
    logic [31:0] p_status, p_cause, p_count, p_compare, p_xctx;
    logic [63:0] p_epc, p_errepc, p_badv, p_taglo, p_lladdr, p_wlo;
    logic [36:0] p_ehi;
    logic [25:0] p_elo0, p_elo1;
    logic [11:0] p_pmask;
    logic [6:0]  p_index;
    logic [4:0]  p_wired, p_random;
    logic [2:0]  p_whi;
    logic [6:0]  p_cfg;
    logic        p_took;
    logic [63:0] p_target;
    fault_t      p_fault;

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic model_reset();
        p_prid = PRID_RESET; p_ratio = 0;
        p_status = 0; p_cause = 0; p_count = 0; p_compare = 0; p_xctx = 0;
        p_epc = 0; p_errepc = 0; p_badv = 0; p_taglo = 0; p_lladdr = 0; p_wlo = 0;
        p_ehi = 0; p_elo0 = 0; p_elo1 = 0; p_pmask = 0; p_index = 0; p_wired = 0;
        p_random = 5'd31; p_whi = 0; p_cfg = 0;
    endtask

    task automatic take_exception(input logic [4:0] code, input logic [63:0] pc,
                                  input logic dly);
        logic [63:0] base;
        if (p_status[1]) begin
            p_fault = FLT_DOUBLE;
            return;
        end
        p_status[1] = 1'b1;
        p_cause[6:2] = code;
        p_epc = dly ? pc - 64'd4 : pc;
        p_cause[31] = dly;
        base = p_status[22] ? VEC_BASE_BEV : VEC_BASE_NORM;
        p_took = 1'b1;
        p_target = base + ((code >= 5'd1 && code <= 5'd3) ? 64'd0 : VEC_GENERAL);
    endtask

    task automatic poll_interrupts(input logic [63:0] pc, input logic dly);
        if (!p_status[0] || p_status[2:1] != 0) return;
        if ((p_status[15:8] & p_cause[15:8]) != 0) take_exception(EXC_INT, pc, dly);
    endtask

    function automatic logic [63:0] cop_reg_value(input logic [4:0] r);
        case (r)
            R_INDEX:   return {32'd0, p_index[6], 25'd0, p_index[5:0]};
            R_RANDOM:  return {59'd0, p_random};
            R_ELO0:    return {38'd0, p_elo0};
            R_ELO1:    return {38'd0, p_elo1};
            R_PMASK:   return {39'd0, p_pmask, 13'd0};
            R_WIRED:   return {59'd0, p_wired};
            R_BADV:    return p_badv;
            R_COUNT:   return {32'd0, p_count};
            R_EHI:     return {p_ehi[36:35], 22'd0, p_ehi[34:8], 5'd0, p_ehi[7:0]};
            R_COMPARE: return {32'd0, p_compare};
            R_STATUS:  return {32'd0, p_status};
            R_CAUSE:   return {32'd0, p_cause};
            R_EPC:     return p_epc;
            R_PRID:    return {32'd0, p_prid};
            R_CONFIG:  return {32'd0, p_ratio, 1'b0, p_cfg[6:4], 5'd0, 4'hD,
                               (11'h646 | {p_cfg[3], 10'd0}), 1'b0, p_cfg[2], p_cfg[1:0]};
            R_LLADDR:  return p_lladdr;
            R_WLO:     return p_wlo;
            R_WHI:     return {61'd0, p_whi};
            R_XCTX:    return {p_xctx[30:0], 33'd0};
            R_TAGLO:   return p_taglo;
            R_ERREPC:  return p_errepc;
            default:   return 64'd0;
        endcase
    endfunction

    task automatic write_cop_reg(input logic [4:0] r, input logic [63:0] v,
                                 input logic [63:0] pc, input logic dly);
        logic [1:0] ksu;
        case (r)
            R_INDEX:   p_index = {v[31], v[5:0]};
            R_ELO0:    p_elo0 = v[25:0];
            R_ELO1:    p_elo1 = v[25:0];
            R_CONTEXT: p_fault = FLT_REG;
            R_PMASK:   p_pmask = v[24:13];
            R_WIRED: begin
                p_wired = v[4:0];
                p_random = 5'd31;
            end
            R_BADV:    p_badv = v;
            R_COUNT:   p_count = v[31:0];
            R_EHI:     p_ehi = {v[63:62], v[39:13], v[7:0]};
            R_COMPARE: begin
                p_compare = v[31:0];
                p_cause[15] = 1'b0;
            end
            R_STATUS: begin
                p_status = v[31:0];
                ksu = p_status[4:3];
                if (p_status[27] || p_status[25] || (p_status[5] && ksu == 2) ||
                    (p_status[6] && ksu == 1) || (p_status[7] && ksu == 0))
                    p_fault = FLT_MODE;
                poll_interrupts(pc, dly);
            end
            R_CAUSE: begin
                p_cause[9:8] = v[9:8];
                poll_interrupts(pc, dly);
            end
            R_EPC:     p_epc = v;
            R_CONFIG:  p_cfg = {v[26:24], v[14], v[2], v[1:0]};
            R_LLADDR:  p_lladdr = v;
            R_WLO:     p_wlo = v & ~64'd4;
            R_WHI:     p_whi = v[2:0];
            R_XCTX:    p_xctx = v[63:32];
            R_TAGLO:   p_taglo = v;
            R_ERREPC:  p_errepc = v;
            default: ;
        endcase
    endtask

    // one request through the predicted coprocessor
    task automatic predict_request(input func_t fn, input logic [4:0] r, input logic [63:0] wd,
                                   input logic [4:0] code, input logic [1:0] copn,
                                   input logic [63:0] badaddr, input logic ldbad,
                                   input logic [63:0] pc, input logic dly,
                                   input logic [2:0] line);
        cop_result_t res;
        res = '0;
        p_took = 0; p_target = 0; p_fault = FLT_NONE;
        case (fn)
            FN_WRITE: write_cop_reg(r, wd, pc, dly);
            FN_READ:  res.read_data = cop_reg_value(r);
            FN_RAISE: begin
                if (ldbad) p_badv = badaddr;
                if (code == EXC_CPU) p_cause[29:28] = copn;
                take_exception(code, pc, dly);
            end
            FN_USABLE: begin
                if (p_status[28] || p_status[4:3] == 0) res.usable = 1'b1;
                else begin
                    p_cause[29:28] = 0;
                    take_exception(EXC_CPU, pc, dly);
                end
            end
            FN_TICK: begin
                p_count = p_count + 32'd1;
                p_random = (p_random == 5'd0) ? 5'd31 : p_random - 5'd1;
                if (p_count == p_compare) begin
                    p_cause[15] = 1'b1;
                    poll_interrupts(pc, dly);
                end
            end
            FN_SET: begin
                p_cause[8 + line] = 1'b1;
                poll_interrupts(pc, dly);
            end
            FN_CLEAR: p_cause[8 + line] = 1'b0;
            default: ;
        endcase
        res.redirect = p_took;
        res.redirect_pc = p_took ? p_target : 64'd0;
        res.fault = p_fault;
        result_q.push_back(res);
    endtask

    // valid is left high after acceptance so requests can follow back to back
    task automatic send_request(input func_t fn, input logic [4:0] r, input logic [63:0] wd,
                                input logic [4:0] code, input logic [1:0] copn,
                                input logic [63:0] badaddr, input logic ldbad,
                                input logic [63:0] pc, input logic dly,
                                input logic [2:0] line);
        while (!sender_calm && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= fn; s_reg_num <= r; s_write_data <= wd; s_exc_code <= code;
        s_cop_number <= copn; s_bad_address <= badaddr; s_load_bad_address <= ldbad;
        s_pc <= pc; s_in_delay_slot <= dly; s_intr_line <= line;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(fn, r, wd, code, copn, badaddr, ldbad, pc, dly, line);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_random(input int weight_status);
        func_t fn;
        logic [63:0] wd;
        logic [4:0] r;
        fn = func_t'($urandom_range(7));
        r = 5'($urandom_range(31));
        wd = rand64();
        // keep exceptions re-enterable and interrupts reachable
        if ($urandom_range(99) < weight_status) begin
            fn = FN_WRITE;
            r = R_STATUS;
            wd[1] = 1'b0;
            if ($urandom_range(1)) wd[27:25] = 0;
        end
        send_request(fn, r, wd, 5'($urandom_range(31)), 2'($urandom_range(3)), rand64(),
                     1'($urandom_range(1)), rand64(), 1'($urandom_range(1)),
                     3'($urandom_range(7)));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_setting(input logic idx, input logic [31:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_PRID) p_prid = val;
        else p_ratio = val[3:0];
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        cop_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                $error("result with nothing expected");
                err_count++;
            end else begin
                want = result_q.pop_front();
                if (m_read_data !== want.read_data) begin
                    $error("read_data exp %h got %h", want.read_data, m_read_data);
                    err_count++;
                end
                if (m_redirect !== want.redirect) begin
                    $error("redirect exp %b got %b", want.redirect, m_redirect);
                    err_count++;
                end
                if (m_redirect_pc !== want.redirect_pc) begin
                    $error("redirect_pc exp %h got %h", want.redirect_pc, m_redirect_pc);
                    err_count++;
                end
                if (m_usable !== want.usable) begin
                    $error("usable exp %b got %b", want.usable, m_usable);
                    err_count++;
                end
                if (m_fault !== want.fault) begin
                    $error("fault exp %0d got %0d", want.fault, m_fault);
                    err_count++;
                end
            end
        end
    end

    // receiver stalls, with a calm stretch and a long hold-off on request
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else
            m_ready <= receiver_calm || ($urandom_range(99) >= 6);
    end

    task automatic test_directed();
        logic [4:0] r;
        // read every third register number at reset, then the extremes
        for (int i = 0; i < 32; i += 3) begin
            r = 5'(i);
            send_request(FN_READ, r, 0, 0, 0, 0, 0, 0, 0, 0);
        end
        send_request(FN_WRITE, R_CONTEXT, '1, 0, 0, 0, 0, 0, 0, 0);
        send_request(FN_WRITE, R_STATUS, 64'h0000_0000_0A00_00E0, 0, 0, 0, 0, 0, 0, 0);
        send_request(FN_WRITE, R_STATUS, 64'h0000_0000_0000_FF01, 0, 0, 0, 0, 0, 0, 0);
        send_request(FN_SET, 0, 0, 0, 0, 0, 0, 64'h1000, 1, 3'd7);
        send_request(FN_RAISE, 0, 0, EXC_CPU, 2'd3, '1, 1, '1, 0, 0);
        send_request(FN_WRITE, R_STATUS, 64'h0000_0000_1040_0018, 0, 0, 0, 0, 0, 0, 0);
        send_request(FN_USABLE, 0, 0, 0, 0, 0, 0, 64'h4, 1, 0);
        send_request(FN_WRITE, R_STATUS, 64'h0000_0000_0040_8011, 0, 0, 0, 0, 0, 0, 0);
        send_request(FN_USABLE, 0, 0, 0, 0, 0, 0, 64'h40, 0, 0);
        send_request(FN_WRITE, R_STATUS, 64'h0000_0000_0000_8001, 0, 0, 0, 0, 0, 0, 0);
        send_request(FN_WRITE, R_COMPARE, 64'd2, 0, 0, 0, 0, 0, 0, 0);
        send_request(FN_WRITE, R_WIRED, '1, 0, 0, 0, 0, 0, 0, 0);
        send_request(FN_TICK, 0, 0, 0, 0, 0, 0, 64'h80, 0, 0);
        send_request(FN_TICK, 0, 0, 0, 0, 0, 0, 64'h80, 0, 0);
        send_request(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 3'd7);
        send_request(FN_NONE, '1, '1, '1, '1, '1, 1, '1, 1, '1);
        send_request(FN_READ, R_CONFIG, 0, 0, 0, 0, 0, 0, 0, 0);
        drain_results();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            sender_calm = (i % 400) > 300;
            receiver_calm = sender_calm;
            send_random(12);
        end
        sender_calm = 0;
        receiver_calm = 0;
        drain_results();
    endtask

    task automatic test_settings();
        write_setting(CFG_PRID, 32'hFFFF_FFFF);
        write_setting(CFG_RATIO, 32'd15);
        send_request(FN_READ, R_PRID, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(FN_READ, R_CONFIG, 0, 0, 0, 0, 0, 0, 0, 0);
        test_random(400);
        write_setting(CFG_PRID, 32'd0);
        write_setting(CFG_RATIO, 32'd0);
        send_request(FN_READ, R_PRID, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(FN_READ, R_CONFIG, 0, 0, 0, 0, 0, 0, 0, 0);
        test_random(400);
        write_setting(CFG_PRID, $urandom);
        write_setting(CFG_RATIO, $urandom_range(15));
    endtask

    task automatic test_backpressure();
        hold_off = 200;
        for (int i = 0; i < 60; i++) send_random(12);
        test_random(400);
    endtask

    initial begin
        err_count = 0; cycle_count = 0; hold_off = 0;
        sender_calm = 0; receiver_calm = 0;
        aresetn = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
        s_valid = 0; s_func = FN_NONE; s_reg_num = 0; s_write_data = 0; s_exc_code = 0;
        s_cop_number = 0; s_bad_address = 0; s_load_bad_address = 0; s_pc = 0;
        s_in_delay_slot = 0; s_intr_line = 0; m_ready = 0;
        model_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_settings();
        test_backpressure();
        drain_results();
        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
